// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the complex stack calculator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define CRSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define CRSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/crsa_pkg.sv
// ---------------------------------------------------------------------------
// Complex stack calculator package
// Sizes, codes, a handshake struct and the saturation helper.
// ---------------------------------------------------------------------------
package crsa_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int DEN_W       = PROD_W;
  localparam int QUO_W       = DATA_W + 2;
  localparam int IT_W        = $clog2(QUO_W);

  typedef enum logic [2:0] {
    KIND_PUSH = 3'd0,
    KIND_ADD  = 3'd1,
    KIND_SUB  = 3'd2,
    KIND_MUL  = 3'd3,
    KIND_DIV  = 3'd4,
    KIND_REAL = 3'd5,
    KIND_IMAG = 3'd6,
    KIND_CONJ = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_DIV0 = 3'd1,
    ST_FEW  = 3'd2,
    ST_FULL = 3'd3,
    ST_SAT  = 3'd4
  } status_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_rsp_t;

  localparam logic [DATA_W-1:0] D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] D_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] S_MAX = {{(ACC_W-DATA_W){1'b0}}, D_MAX};
  localparam logic signed [ACC_W-1:0] S_MIN = {{(ACC_W-DATA_W){1'b1}}, D_MIN};

  // Clamps a wide signed value to 32 bits; the top bit flags a clamp.
  function automatic logic [DATA_W:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [DATA_W:0] r;
    if (v > S_MAX) begin
      r = {1'b1, D_MAX};
    end else if (v < S_MIN) begin
      r = {1'b1, D_MIN};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/crsa_divider.sv
// ---------------------------------------------------------------------------
// Fixed-point quotient unit
// Restoring divider giving one quotient bit a cycle, with saturation.
// ---------------------------------------------------------------------------
module crsa_divider (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  go,
  input  logic signed [crsa_pkg::ACC_W-1:0]     num,
  input  logic        [crsa_pkg::DEN_W-1:0]     den,
  output crsa_pkg::div_rsp_t                    rsp,
  output logic        [crsa_pkg::DATA_W-1:0]    quo
);
  import crsa_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_ITER = 3'b010,
    D_FIN  = 3'b100
  } dstate_t;

  dstate_t              state_r, state_nxt;
  logic                 neg_r, neg_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [QUO_W-1:0]     lo_r, lo_nxt;
  logic [QUO_W-1:0]     q_r, q_nxt;
  logic [IT_W-1:0]      it_r, it_nxt;

  logic [ACC_W-1:0]     mag_full;
  logic [DEN_W-1:0]     mag;
  logic [DEN_W-1:0]     hi;
  logic [DEN_W:0]       rem2;
  logic                 take;

  assign mag_full = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign mag      = mag_full[DEN_W-1:0];
  assign hi       = mag >> (QUO_W - FRAC_BITS);
  assign rem2     = {rem_r, lo_r[QUO_W-1]};
  assign take     = rem2 >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    lo_nxt    = lo_r;
    q_nxt     = q_r;
    it_nxt    = it_r;
    unique case (state_r)
      D_IDLE: begin
        if (go) begin
          neg_nxt = num[ACC_W-1];
          den_nxt = den;
          // A quotient of 2^34 or more always saturates, so skip the bits.
          ovf_nxt = hi >= den;
          rem_nxt = hi;
          lo_nxt  = QUO_W'(mag << FRAC_BITS);
          q_nxt   = '0;
          it_nxt  = '0;
          state_nxt = (hi >= den) ? D_FIN : D_ITER;
        end
      end
      D_ITER: begin
        rem_nxt = take ? DEN_W'(rem2 - {1'b0, den_r}) : rem2[DEN_W-1:0];
        lo_nxt  = {lo_r[QUO_W-2:0], 1'b0};
        q_nxt   = {q_r[QUO_W-2:0], take};
        it_nxt  = IT_W'(it_r + 1'b1);
        if (it_r == IT_W'(QUO_W - 1)) begin
          state_nxt = D_FIN;
        end
      end
      D_FIN: begin
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.done = state_r == D_FIN;
    rsp.sat  = 1'b0;
    quo      = q_r[DATA_W-1:0];
    if (ovf_r) begin
      rsp.sat = 1'b1;
      quo     = neg_r ? D_MIN : D_MAX;
    end else if (!neg_r) begin
      if (q_r > QUO_W'(D_MAX)) begin
        rsp.sat = 1'b1;
        quo     = D_MAX;
      end
    end else if (q_r > QUO_W'(D_MIN)) begin
      rsp.sat = 1'b1;
      quo     = D_MIN;
    end else begin
      quo = DATA_W'(-q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    it_r  <= it_nxt;
  end

endmodule

// File: rtl/complex_rpn_stack_alu_top.sv
// ---------------------------------------------------------------------------
// Complex RPN stack calculator
// Q16.16 complex operand stack with add, subtract, multiply, divide,
// unary part selection and conjugate, driven one request at a time.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with out_valid high; the receiver
// cannot stall it, so it must capture the result in that cycle. Push, the
// unary operations and every refused request are handled in the idle state,
// with the result in the following cycle. Add and subtract pass through a
// fetch state that reads the second operand and a write-back state. Multiply
// uses the single shared 32 by 32 multiplier that forms the four partial
// products one after another, each in a multiply state and then an
// accumulate state. Divide forms six products through the same multiplier,
// then two quotients from a restoring divider that resolves one bit per
// cycle, each quotient with a launch and a finish state around its bit
// steps; a zero denominator skips the quotients. The block holds busy high
// until the result is presented and can take the next request in the cycle
// that shows the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_rpn_stack_alu_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          in_kind,
  input  logic signed [crsa_pkg::DATA_W-1:0]  in_push_real,
  input  logic signed [crsa_pkg::DATA_W-1:0]  in_push_imag,
  output logic                                out_valid,
  output logic signed [crsa_pkg::DATA_W-1:0]  out_top_real,
  output logic signed [crsa_pkg::DATA_W-1:0]  out_top_imag,
  output logic [4:0]                          out_stack_depth,
  output logic [2:0]                          out_status
);
  import crsa_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FETCH  = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_ACC    = 7'b0001000,
    S_DSTART = 7'b0010000,
    S_DWAIT  = 7'b0100000,
    S_WB     = 7'b1000000
  } state_t;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  // The operand stack: two memories, one for each component.
  logic signed [DATA_W-1:0] mem_real [STACK_DEPTH];
  logic signed [DATA_W-1:0] mem_imag [STACK_DEPTH];

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] top_real_r, top_real_nxt;
  logic signed [DATA_W-1:0] top_imag_r, top_imag_nxt;
  kind_t                    kind_r, kind_nxt;
  logic [2:0]               step_r, step_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic signed [ACC_W-1:0]  num_re_r, num_re_nxt;
  logic signed [ACC_W-1:0]  num_im_r, num_im_nxt;
  logic signed [DATA_W-1:0] res_real_r, res_real_nxt;
  logic signed [DATA_W-1:0] res_imag_r, res_imag_nxt;
  logic                     sat_r, sat_nxt;
  logic                     div0_r, div0_nxt;
  logic                     comp_r, comp_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_real_r, out_real_nxt;
  logic signed [DATA_W-1:0] out_imag_r, out_imag_nxt;
  logic [CNT_W-1:0]         out_cnt_r, out_cnt_nxt;
  status_t                  out_status_r, out_status_nxt;

  // Second operand, read from the stack when a binary request is taken.
  logic signed [DATA_W-1:0] b_real_r;
  logic signed [DATA_W-1:0] b_imag_r;

  logic                     accept;
  kind_t                    in_kind_e;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] mem_wreal;
  logic signed [DATA_W-1:0] mem_wimag;

  logic signed [DATA_W-1:0] mul_x;
  logic signed [DATA_W-1:0] mul_y;
  logic                     acc_sub;
  logic                     grp_end;
  logic signed [ACC_W-1:0]  acc_sum;
  logic [DATA_W:0]          sat_re;
  logic [DATA_W:0]          sat_im;
  logic [DATA_W:0]          sat_acc;
  logic [CNT_W-1:0]         cnt_m1;
  logic [CNT_W-1:0]         cnt_m2;

  logic                     div_go;
  logic signed [ACC_W-1:0]  div_num;
  div_rsp_t                 div_rsp;
  logic [DATA_W-1:0]        div_quo;

  assign accept    = start && !busy;
  assign in_kind_e = kind_t'(in_kind);
  assign busy      = state_r != S_IDLE;
  assign cnt_m1    = CNT_W'(cnt_r - CNT_ONE);
  assign cnt_m2    = CNT_W'(cnt_r - CNT_TWO);
  assign rd_addr   = cnt_m2[ADDR_W-1:0];
  assign div_num   = comp_r ? num_im_r : num_re_r;

  // Operand selection for the shared multiplier. The top entry is a, the one
  // below it is b. Multiply forms ar*br, ai*bi, ar*bi, ai*br. Divide first
  // forms the denominator br*br + bi*bi, then the two numerators.
  always_comb begin
    mul_x   = top_real_r;
    mul_y   = b_real_r;
    acc_sub = 1'b0;
    grp_end = 1'b0;
    if (kind_r == KIND_MUL) begin
      case (step_r)
        3'd0: begin mul_x = top_real_r; mul_y = b_real_r; end
        3'd1: begin mul_x = top_imag_r; mul_y = b_imag_r; acc_sub = 1'b1; grp_end = 1'b1; end
        3'd2: begin mul_x = top_real_r; mul_y = b_imag_r; end
        default: begin mul_x = top_imag_r; mul_y = b_real_r; grp_end = 1'b1; end
      endcase
    end else begin
      case (step_r)
        3'd0: begin mul_x = b_real_r; mul_y = b_real_r; end
        3'd1: begin mul_x = b_imag_r; mul_y = b_imag_r; grp_end = 1'b1; end
        3'd2: begin mul_x = top_real_r; mul_y = b_real_r; end
        3'd3: begin mul_x = top_imag_r; mul_y = b_imag_r; grp_end = 1'b1; end
        3'd4: begin mul_x = top_imag_r; mul_y = b_real_r; end
        default: begin mul_x = top_real_r; mul_y = b_imag_r; acc_sub = 1'b1; grp_end = 1'b1; end
      endcase
    end
  end

  assign acc_sum = acc_sub ? ACC_W'(acc_r - ACC_W'(prod_r)) : ACC_W'(acc_r + ACC_W'(prod_r));
  assign sat_acc = sat32(acc_sum >>> FRAC_BITS);

  // Add and subtract results from the cached top entry and the second operand.
  always_comb begin
    sat_re = sat32(ACC_W'(top_real_r) + ACC_W'(b_real_r));
    sat_im = sat32(ACC_W'(top_imag_r) + ACC_W'(b_imag_r));
    if (kind_r == KIND_SUB) begin
      sat_re = sat32(ACC_W'(top_real_r) - ACC_W'(b_real_r));
      sat_im = sat32(ACC_W'(top_imag_r) - ACC_W'(b_imag_r));
    end
  end

  always_comb begin
    logic [DATA_W:0] neg_im;
    neg_im = sat32(-ACC_W'(top_imag_r));

    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    top_real_nxt   = top_real_r;
    top_imag_nxt   = top_imag_r;
    kind_nxt       = kind_r;
    step_nxt       = step_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    den_nxt        = den_r;
    num_re_nxt     = num_re_r;
    num_im_nxt     = num_im_r;
    res_real_nxt   = res_real_r;
    res_imag_nxt   = res_imag_r;
    sat_nxt        = sat_r;
    div0_nxt       = div0_r;
    comp_nxt       = comp_r;
    out_valid_nxt  = 1'b0;
    out_real_nxt   = out_real_r;
    out_imag_nxt   = out_imag_r;
    out_cnt_nxt    = out_cnt_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cnt_m1[ADDR_W-1:0];
    mem_wreal      = res_real_r;
    mem_wimag      = res_imag_r;
    div_go         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Refused requests report the unchanged stack.
          out_valid_nxt  = 1'b1;
          out_real_nxt   = (cnt_r == '0) ? '0 : top_real_r;
          out_imag_nxt   = (cnt_r == '0) ? '0 : top_imag_r;
          out_cnt_nxt    = cnt_r;
          out_status_nxt = ST_OK;
          case (in_kind_e)
            KIND_PUSH: begin
              if (cnt_r >= CNT_FULL) begin
                out_status_nxt = ST_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = cnt_r[ADDR_W-1:0];
                mem_wreal    = in_push_real;
                mem_wimag    = in_push_imag;
                top_real_nxt = in_push_real;
                top_imag_nxt = in_push_imag;
                cnt_nxt      = CNT_W'(cnt_r + CNT_ONE);
                out_real_nxt = in_push_real;
                out_imag_nxt = in_push_imag;
                out_cnt_nxt  = CNT_W'(cnt_r + CNT_ONE);
              end
            end
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
              if (cnt_r < CNT_TWO) begin
                out_status_nxt = ST_FEW;
              end else begin
                // The result comes later from the write-back state.
                out_valid_nxt = 1'b0;
                rd_en         = 1'b1;
                kind_nxt      = in_kind_e;
                sat_nxt       = 1'b0;
                div0_nxt      = 1'b0;
                comp_nxt      = 1'b0;
                state_nxt     = S_FETCH;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                out_status_nxt = ST_FEW;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_m1[ADDR_W-1:0];
                mem_wreal = top_real_r;
                mem_wimag = top_imag_r;
                if (in_kind_e == KIND_REAL) begin
                  mem_wimag = '0;
                end else if (in_kind_e == KIND_IMAG) begin
                  mem_wreal = '0;
                end else begin
                  mem_wimag = neg_im[DATA_W-1:0];
                  if (neg_im[DATA_W]) begin
                    out_status_nxt = ST_SAT;
                  end
                end
                top_real_nxt = mem_wreal;
                top_imag_nxt = mem_wimag;
                out_real_nxt = mem_wreal;
                out_imag_nxt = mem_wimag;
              end
            end
          endcase
        end
      end
      S_FETCH: begin
        if (kind_r == KIND_ADD || kind_r == KIND_SUB) begin
          res_real_nxt = sat_re[DATA_W-1:0];
          res_imag_nxt = sat_im[DATA_W-1:0];
          sat_nxt      = sat_re[DATA_W] | sat_im[DATA_W];
          state_nxt    = S_WB;
        end else begin
          step_nxt  = '0;
          acc_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(mul_x * mul_y);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt   = grp_end ? '0 : acc_sum;
        step_nxt  = 3'(step_r + 1'b1);
        state_nxt = S_MUL;
        if (kind_r == KIND_MUL) begin
          if (step_r == 3'd1) begin
            res_real_nxt = sat_acc[DATA_W-1:0];
            sat_nxt      = sat_r | sat_acc[DATA_W];
          end else if (step_r == 3'd3) begin
            res_imag_nxt = sat_acc[DATA_W-1:0];
            sat_nxt      = sat_r | sat_acc[DATA_W];
            state_nxt    = S_WB;
          end
        end else begin
          if (step_r == 3'd1) begin
            den_nxt = acc_sum[DEN_W-1:0];
          end else if (step_r == 3'd3) begin
            num_re_nxt = acc_sum;
          end else if (step_r == 3'd5) begin
            num_im_nxt = acc_sum;
            state_nxt  = S_DSTART;
          end
        end
      end
      S_DSTART: begin
        if (den_r == '0) begin
          // A zero divisor pushes zero.
          res_real_nxt = '0;
          res_imag_nxt = '0;
          div0_nxt     = 1'b1;
          state_nxt    = S_WB;
        end else begin
          div_go    = 1'b1;
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          sat_nxt = sat_r | div_rsp.sat;
          if (!comp_r) begin
            res_real_nxt = div_quo;
            comp_nxt     = 1'b1;
            state_nxt    = S_DSTART;
          end else begin
            res_imag_nxt = div_quo;
            state_nxt    = S_WB;
          end
        end
      end
      S_WB: begin
        // The result replaces b, which becomes the new top.
        mem_we         = 1'b1;
        mem_waddr      = cnt_m2[ADDR_W-1:0];
        top_real_nxt   = res_real_r;
        top_imag_nxt   = res_imag_r;
        cnt_nxt        = cnt_m1;
        out_valid_nxt  = 1'b1;
        out_real_nxt   = res_real_r;
        out_imag_nxt   = res_imag_r;
        out_cnt_nxt    = cnt_m1;
        out_status_nxt = div0_r ? ST_DIV0 : (sat_r ? ST_SAT : ST_OK);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  crsa_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (den_r),
    .rsp   (div_rsp),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_real[mem_waddr] <= mem_wreal;
      mem_imag[mem_waddr] <= mem_wimag;
    end
    if (rd_en) begin
      b_real_r <= mem_real[rd_addr];
      b_imag_r <= mem_imag[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_real_r   <= top_real_nxt;
    top_imag_r   <= top_imag_nxt;
    kind_r       <= kind_nxt;
    step_r       <= step_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    den_r        <= den_nxt;
    num_re_r     <= num_re_nxt;
    num_im_r     <= num_im_nxt;
    res_real_r   <= res_real_nxt;
    res_imag_r   <= res_imag_nxt;
    sat_r        <= sat_nxt;
    div0_r       <= div0_nxt;
    comp_r       <= comp_nxt;
    out_real_r   <= out_real_nxt;
    out_imag_r   <= out_imag_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_top_real    = out_real_r;
  assign out_top_imag    = out_imag_r;
  assign out_stack_depth = 5'(out_cnt_r);
  assign out_status      = out_status_r;

  // A result is only ever shown while the block can take the next request.
  `CRSA_ASSERT(a_out_not_busy, out_valid_r |-> !busy, "result shown while busy")
  // Write-back always presents its result in the following cycle.
  `CRSA_ASSERT_NEXT(a_wb_result, state_r == S_WB, out_valid_r, "write-back without result")
  // The entry count never passes the stack size.
  `CRSA_ASSERT(a_cnt_bound, cnt_r <= CNT_FULL, "entry count beyond stack size")
  // The divider finishes only while the sequencer waits for it.
  `CRSA_ASSERT(a_div_done, div_rsp.done |-> state_r == S_DWAIT, "stray divider completion")

endmodule
